FILE: sv/drft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drft_pkg
// Shared types and grid constants of the dirty-rectangle frame tracker.
// ----------------------------------------------------------------------------
package drft_pkg;

    // grid geometry
    localparam int GRID_SIDE  = 20;
    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int POS_W      = $clog2(GRID_CELLS + 1);
    localparam int ADDR_W     = $clog2(GRID_CELLS);
    localparam int COORD_W    = $clog2(GRID_SIDE + 1);
    localparam int BOX_W      = 5;

    // one input transfer
    typedef struct packed {
        logic       command;
        logic [7:0] cell_code;
        logic [7:0] palette_id;
        logic       frame_end;
    } t_in_item;

    // one result transfer
    typedef struct packed {
        logic [BOX_W-1:0] box_x_min;
        logic [BOX_W-1:0] box_y_min;
        logic [BOX_W-1:0] box_x_max;
        logic [BOX_W-1:0] box_y_max;
        logic             full_redraw;
    } t_out_item;

    // store write port
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    // item held in the compare stage
    typedef struct packed {
        logic               is_cmd;
        logic               is_cell;
        logic               in_grid;
        logic               complete;
        logic               frame_end;
        logic [7:0]         cell_code;
        logic [7:0]         palette_id;
        logic [ADDR_W-1:0]  addr;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } t_stage;

endpackage

FILE: sv/dirty_rect_frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rect_frame_tracker
// Tracks the changed region of a palette-code grid from frame to frame.
// ----------------------------------------------------------------------------
// Takes one transfer per clock cycle, sustained, as long as results are taken.
// A cell is read from the previous-frame store when it is accepted and
// compared, stored and merged into the box from the compare-stage register;
// a frame result is registered in the output register as its last cell leaves
// that stage. The rate is set by the store's single read and write port, used
// once per cell. There is no clearing pass after reset: the store is filled
// by the first complete frame, which is always reported as a full redraw.
// ----------------------------------------------------------------------------
module dirty_rect_frame_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  drft_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output drft_pkg::t_out_item o_out_data
);
    import drft_pkg::*;

    localparam logic [POS_W-1:0]   POS_END = POS_W'(GRID_CELLS);
    localparam logic [COORD_W-1:0] SIDE_M1 = COORD_W'(GRID_SIDE - 1);

    logic               r_active;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic               r_s1_valid;
    t_stage             r_s1;
    t_stage             n_s1;
    t_mem_wr            mem_wr;
    logic [7:0]         prev_code;
    logic               s1_move;
    logic               accept;
    logic               in_grid;
    logic               is_cell;

    assign o_in_ready = !r_s1_valid || s1_move;
    assign accept     = i_in_valid && o_in_ready;
    assign is_cell    = !i_in_data.command && r_active;
    assign in_grid    = (r_pos < POS_END);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_active <= i_cfg_wr_data;
        end
    end

    // advance the raster position
    always_comb begin
        n_pos = r_pos;
        n_col = r_col;
        n_row = r_row;
        if (in_grid) begin
            n_pos = r_pos + 1'b1;
            if (r_col == SIDE_M1) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_col <= '0;
            r_row <= '0;
        end else if (accept && is_cell) begin
            if (i_in_data.frame_end) begin
                r_pos <= '0;
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_pos <= n_pos;
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    // build the compare-stage entry
    always_comb begin
        n_s1.is_cmd     = i_in_data.command;
        n_s1.is_cell    = is_cell;
        n_s1.in_grid    = in_grid;
        n_s1.complete   = (n_pos == POS_END);
        n_s1.frame_end  = i_in_data.frame_end;
        n_s1.cell_code  = i_in_data.cell_code;
        n_s1.palette_id = i_in_data.palette_id;
        n_s1.addr       = r_pos[ADDR_W-1:0];
        n_s1.col        = r_col;
        n_s1.row        = r_row;
    end

    // compare-stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
    end

    drft_frame_mem u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_pos[ADDR_W-1:0]),
        .i_wr      (mem_wr),
        .o_rd_data (prev_code)
    );

    drft_box_unit u_box (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_s1_valid),
        .i_s1        (r_s1),
        .i_prev_code (prev_code),
        .o_wr        (mem_wr),
        .o_s1_move   (s1_move),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // position never runs past the grid
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= POS_END) && (r_col <= SIDE_M1))
        else $error("raster position out of range");

    // a stalled compare stage keeps its entry
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(r_s1)))
        else $error("compare stage lost its entry while stalled");

    // a full redraw covers the whole grid
    a_full_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.full_redraw) |->
        (o_out_data.box_x_min == '0 && o_out_data.box_y_min == '0 &&
         o_out_data.box_x_max == BOX_W'(SIDE_M1) &&
         o_out_data.box_y_max == BOX_W'(SIDE_M1)))
        else $error("full redraw box is not the whole grid");

endmodule

FILE: sv/drft_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drft_frame_mem
// Previous-frame code store: one registered read, one write, with forwarding
// of a write that lands on the address being read in the same cycle.
// ----------------------------------------------------------------------------
module drft_frame_mem (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [drft_pkg::ADDR_W-1:0] i_rd_addr,
    input  drft_pkg::t_mem_wr        i_wr,
    output logic [7:0]               o_rd_data
);
    import drft_pkg::*;

    logic [7:0] r_mem [GRID_CELLS];
    logic [7:0] r_rdata;
    logic [7:0] r_fwd_data;
    logic       r_fwd;

    // write the new code
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read the old code, capture a colliding write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rdata    <= r_mem[i_rd_addr];
            r_fwd      <= i_wr.en && (i_wr.addr == i_rd_addr);
            r_fwd_data <= i_wr.data;
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rdata;

endmodule

FILE: sv/drft_box_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drft_box_unit
// Compare stage: detects changed cells, widens the running box, decides the
// frame result and holds it in the output register.
// ----------------------------------------------------------------------------
module drft_box_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s1_valid,
    input  drft_pkg::t_stage    i_s1,
    input  logic [7:0]          i_prev_code,
    output drft_pkg::t_mem_wr   o_wr,
    output logic                o_s1_move,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output drft_pkg::t_out_item o_out_data
);
    import drft_pkg::*;

    localparam logic [COORD_W-1:0] LO_INIT = COORD_W'(GRID_SIDE);
    localparam logic [COORD_W-1:0] SIDE_M1 = COORD_W'(GRID_SIDE - 1);

    logic [COORD_W-1:0] r_x_lo, r_y_lo, r_x_hi, r_y_hi;
    logic [COORD_W-1:0] n_x_lo, n_y_lo, n_x_hi, n_y_hi;
    logic               r_seen, n_seen;
    logic               r_prev_valid;
    logic [7:0]         r_prev_pal;
    logic               r_pending;
    logic               r_out_valid;
    t_out_item          r_out_data;
    logic               fire;
    logic               changed;
    logic               at_end;
    logic               full;
    logic               emit;

    assign o_s1_move = !r_out_valid || i_out_ready;
    assign fire      = i_s1_valid && o_s1_move;
    assign changed   = i_s1.is_cell && i_s1.in_grid && (i_prev_code != i_s1.cell_code);
    assign at_end    = fire && i_s1.is_cell && i_s1.frame_end;
    assign full      = r_pending || !r_prev_valid || (i_s1.palette_id != r_prev_pal);
    assign emit      = full || n_seen;

    // store the new code of an in-grid cell
    assign o_wr.en   = fire && i_s1.is_cell && i_s1.in_grid;
    assign o_wr.addr = i_s1.addr;
    assign o_wr.data = i_s1.cell_code;

    // widen the box with a changed cell
    always_comb begin
        n_x_lo = r_x_lo;
        n_y_lo = r_y_lo;
        n_x_hi = r_x_hi;
        n_y_hi = r_y_hi;
        n_seen = r_seen;
        if (changed) begin
            if (i_s1.col < r_x_lo) n_x_lo = i_s1.col;
            if (i_s1.row < r_y_lo) n_y_lo = i_s1.row;
            if (!r_seen || i_s1.col > r_x_hi) n_x_hi = i_s1.col;
            if (!r_seen || i_s1.row > r_y_hi) n_y_hi = i_s1.row;
            n_seen = 1'b1;
        end
    end

    // track box and frame history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_lo       <= LO_INIT;
            r_y_lo       <= LO_INIT;
            r_x_hi       <= '0;
            r_y_hi       <= '0;
            r_seen       <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev_pal   <= '0;
            r_pending    <= 1'b0;
        end else if (fire) begin
            if (i_s1.is_cmd) begin
                r_pending <= 1'b1;
            end else if (at_end) begin
                r_x_lo     <= LO_INIT;
                r_y_lo     <= LO_INIT;
                r_x_hi     <= '0;
                r_y_hi     <= '0;
                r_seen     <= 1'b0;
                r_pending  <= 1'b0;
                r_prev_pal <= i_s1.palette_id;
                if (i_s1.complete) r_prev_valid <= 1'b1;
            end else begin
                r_x_lo <= n_x_lo;
                r_y_lo <= n_y_lo;
                r_x_hi <= n_x_hi;
                r_y_hi <= n_y_hi;
                r_seen <= n_seen;
            end
        end
    end

    // hold the result until its transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (at_end && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (at_end && emit) begin
            r_out_data.full_redraw <= full;
            r_out_data.box_x_min   <= full ? '0 : BOX_W'(n_x_lo);
            r_out_data.box_y_min   <= full ? '0 : BOX_W'(n_y_lo);
            r_out_data.box_x_max   <= BOX_W'(full ? SIDE_M1 : n_x_hi);
            r_out_data.box_y_max   <= BOX_W'(full ? SIDE_M1 : n_y_hi);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a pending repaint always yields a full redraw at frame end
    a_pending_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (at_end && r_pending) |=> (r_out_valid && r_out_data.full_redraw))
        else $error("pending repaint did not force a full redraw");

    // box stays ordered once a change is seen
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_x_lo <= r_x_hi && r_y_lo <= r_y_hi))
        else $error("running box out of order");

endmodule
